FILE: rtl/core/pgsg_pkg.sv
// pgsg_pkg: types, constants and helpers shared by the polar Gaussian sample
// generator modules. No dependencies.
package pgsg_pkg;

  localparam logic [24:0] TWO_LN2_Q24 = 25'd23258160;
  localparam logic [31:0] MEAN_RESET  = 32'd0;
  localparam logic [31:0] SIGMA_RESET = 32'd65536;

  localparam logic CFG_MEAN  = 1'b0;
  localparam logic CFG_SIGMA = 1'b1;

  localparam logic [5:0] LOG_LAST  = 6'd31;
  localparam logic [5:0] DIV_LAST  = 6'd32;
  localparam logic [5:0] SQRT_LAST = 6'd27;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SQA, OP_SQB, OP_SUMW, OP_PICK, OP_NORM, OP_MINIT,
    OP_LOG, OP_LSCALE, OP_VSQ, OP_DINIT, OP_DIV, OP_XSQ, OP_SINIT, OP_SQRT,
    OP_MAG, OP_RND, OP_SUM
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQA, ST_SQB, ST_SUMW, ST_TEST, ST_NORM, ST_LOG, ST_LSCALE,
    ST_VSQ, ST_DINIT, ST_DIV, ST_XSQ, ST_SINIT, ST_SQRT, ST_MAG, ST_RND, ST_SUM
  } state_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic reject;
    logic norm_done;
  } dp_stat_t;

  // |u - 1/2| in units of 2^-32
  function automatic logic [31:0] fold_mag(input logic [31:0] u);
    logic [31:0] r;
    if (u[31]) begin
      r = {1'b0, u[30:0]};
    end else begin
      r = 32'h8000_0000 - u;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/pgsg_dp.sv
// pgsg_dp: datapath of the polar Gaussian generator: config registers,
// squares, normalize, log2 by squaring, restoring divider, isqrt, scale.
// Depends on pgsg_pkg.
module pgsg_dp import pgsg_pkg::*; #(
  parameter int UniformWidth = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [31:0] uniform_a_i,
  input  logic [31:0] uniform_b_i,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  output logic signed [31:0] sample_o,
  output logic        clipped_o
);

  localparam int UpShift = (UniformWidth < 32) ? 32 - UniformWidth : 0;
  localparam int DnShift = (UniformWidth > 32) ? UniformWidth - 32 : 0;

  logic [31:0] mean_q, sigma_q;
  logic        sel_q;

  logic [31:0] a1_q, a2_q, av_q;
  logic        n1_q, n2_q, neg_q;
  logic [63:0] p_q, w_q;
  logic [62:0] nrm_q;
  logic [5:0]  k_q;
  logic [31:0] m_q, f_q;
  logic [30:0] lq_q;
  logic [31:0] wn_q;
  logic [32:0] rem_q, quo_q;
  logic [55:0] sx_q, r_q, bit_q;
  logic [36:0] mag_q;
  logic signed [31:0] sample_q;
  logic        clipped_q;

  logic [31:0] ua, ub;
  logic [63:0] z;
  logic [37:0] nl2;
  logic [4:0]  s;
  logic        ge;
  logic [32:0] r2;
  logic [55:0] rb;
  logic signed [37:0] sum;

  assign ua = (uniform_a_i << UpShift) >> DnShift;
  assign ub = (uniform_b_i << UpShift) >> DnShift;

  assign z   = m_q * m_q;
  assign nl2 = {6'd62 - k_q, 32'd0} - {6'd0, f_q};
  assign s   = (k_q > 6'd31) ? 5'(k_q - 6'd31) : 5'd0;
  assign ge  = rem_q >= {1'b0, wn_q};
  assign r2  = ge ? rem_q - {1'b0, wn_q} : rem_q;
  assign rb  = r_q + bit_q;
  assign sum = neg_q ? 38'(signed'(mean_q)) - signed'({1'b0, mag_q})
                     : 38'(signed'(mean_q)) + signed'({1'b0, mag_q});

  assign stat_o.reject    = (w_q == 64'd0) || w_q[63] || (w_q[62] && (|w_q[61:0]));
  assign stat_o.norm_done = nrm_q[62];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q  <= MEAN_RESET;
      sigma_q <= SIGMA_RESET;
      sel_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MEAN:  mean_q  <= cfg_data_i;
          CFG_SIGMA: sigma_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == OP_PICK) begin
        sel_q <= ~sel_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        a1_q <= fold_mag(ua);
        a2_q <= fold_mag(ub);
        n1_q <= ~ua[31];
        n2_q <= ~ub[31];
      end
      OP_SQA: p_q <= a1_q * a1_q;
      OP_SQB: begin
        w_q <= p_q;
        p_q <= a2_q * a2_q;
      end
      OP_SUMW: w_q <= w_q + p_q;
      OP_PICK: begin
        av_q  <= sel_q ? a2_q : a1_q;
        neg_q <= sel_q ? n2_q : n1_q;
        nrm_q <= w_q[62:0];
        k_q   <= 6'd62;
      end
      OP_NORM: begin
        nrm_q <= {nrm_q[61:0], 1'b0};
        k_q   <= k_q - 6'd1;
      end
      OP_MINIT: begin
        m_q <= nrm_q[62:31];
        f_q <= 32'd0;
      end
      OP_LOG: begin
        if (z[63]) begin
          f_q <= {f_q[30:0], 1'b1};
          m_q <= z[63:32];
        end else begin
          f_q <= {f_q[30:0], 1'b0};
          m_q <= z[62:31];
        end
      end
      OP_LSCALE: p_q <= nl2 * TWO_LN2_Q24;
      OP_VSQ: begin
        lq_q <= 31'((p_q + 64'h8000_0000) >> 32);
        p_q  <= av_q * av_q;
      end
      OP_DINIT: begin
        wn_q  <= 32'(w_q >> s);
        rem_q <= 33'(p_q >> s);
        quo_q <= 33'd0;
      end
      OP_DIV: begin
        rem_q <= {r2[31:0], 1'b0};
        quo_q <= {quo_q[31:0], ge};
      end
      OP_XSQ: p_q <= quo_q * lq_q;
      OP_SINIT: begin
        sx_q  <= {p_q[63:24], 16'd0};
        r_q   <= 56'd0;
        bit_q <= 56'd1 << 54;
      end
      OP_SQRT: begin
        if (sx_q >= rb) begin
          sx_q <= sx_q - rb;
          r_q  <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_MAG: p_q <= sigma_q * r_q[27:0];
      OP_RND: mag_q <= 37'((p_q + 64'h80_0000) >> 24);
      OP_SUM: begin
        if (sum > 38'sh0_7FFF_FFFF) begin
          sample_q  <= 32'h7FFF_FFFF;
          clipped_q <= 1'b1;
        end else if (sum < -38'sh0_8000_0000) begin
          sample_q  <= 32'h8000_0000;
          clipped_q <= 1'b1;
        end else begin
          sample_q  <= sum[31:0];
          clipped_q <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign sample_o  = sample_q;
  assign clipped_o = clipped_q;

endmodule

FILE: rtl/core/pgsg_ctrl.sv
// pgsg_ctrl: sequencer for the polar Gaussian generator; drives datapath
// commands, iteration counts and both handshakes. Depends on pgsg_pkg.
module pgsg_ctrl import pgsg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e     state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q + 6'd1;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_SQA;
        end
      end
      ST_SQA: begin
        cmd_o.op = OP_SQA;
        state_d  = ST_SQB;
      end
      ST_SQB: begin
        cmd_o.op = OP_SQB;
        state_d  = ST_SUMW;
      end
      ST_SUMW: begin
        cmd_o.op = OP_SUMW;
        state_d  = ST_TEST;
      end
      ST_TEST: begin
        if (stat_i.reject) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.op = OP_PICK;
          state_d  = ST_NORM;
        end
      end
      ST_NORM: begin
        if (stat_i.norm_done) begin
          cmd_o.op = OP_MINIT;
          cnt_d    = 6'd0;
          state_d  = ST_LOG;
        end else begin
          cmd_o.op = OP_NORM;
        end
      end
      ST_LOG: begin
        cmd_o.op = OP_LOG;
        if (cnt_q == LOG_LAST) state_d = ST_LSCALE;
      end
      ST_LSCALE: begin
        cmd_o.op = OP_LSCALE;
        state_d  = ST_VSQ;
      end
      ST_VSQ: begin
        cmd_o.op = OP_VSQ;
        state_d  = ST_DINIT;
      end
      ST_DINIT: begin
        cmd_o.op = OP_DINIT;
        cnt_d    = 6'd0;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        if (cnt_q == DIV_LAST) state_d = ST_XSQ;
      end
      ST_XSQ: begin
        cmd_o.op = OP_XSQ;
        state_d  = ST_SINIT;
      end
      ST_SINIT: begin
        cmd_o.op = OP_SINIT;
        cnt_d    = 6'd0;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.op = OP_SQRT;
        if (cnt_q == SQRT_LAST) state_d = ST_MAG;
      end
      ST_MAG: begin
        cmd_o.op = OP_MAG;
        state_d  = ST_RND;
      end
      ST_RND: begin
        cmd_o.op = OP_RND;
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        if (!(out_valid_q && out_stall_i)) begin
          cmd_o.op    = OP_SUM;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/polar_gaussian_sample_generator_unit.sv
// Polar-method Gaussian sample generator, top level.
// Instantiates pgsg_ctrl and pgsg_dp; depends on pgsg_pkg.
//
// Input channel: one word carries two uniform samples (uniform_a_i,
// uniform_b_i), taken when in_valid_i is high and in_stall_o is low.
// in_stall_o is low only while the sequencer is idle: one pair at a time.
// Output channel: sample_o (signed Q16.16) and clipped_o, offered with
// out_valid_o and held until a cycle with out_stall_i low.
// Configuration: cfg_we_i writes cfg_data_i to mean (index 0) or sigma
// (index 1); write only while idle.
// Timing: a rejected pair (outside the unit circle or at the origin) frees
// the input after its square, sum and test steps, and offers no word. An
// accepted pair offers its word and frees the input in the same cycle, after
// 0 to 62 normalize shifts, 32 log2 squarings, 33 divide and 28 square-root
// steps.
// The finished word sits in the output register, so a new pair is taken
// while it waits; a stalled receiver only holds the last step of the next
// pair once that one is done.
// Reset: mean 0, sigma 1.0, coordinate toggle back to the first one, no
// word pending.
module polar_gaussian_sample_generator_unit import pgsg_pkg::*; #(
  parameter int UniformWidth = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] uniform_a_i,
  input  logic [31:0] uniform_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] sample_o,
  output logic        clipped_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pgsg_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .out_valid_o,
    .out_stall_i,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  pgsg_dp #(
    .UniformWidth (UniformWidth)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .uniform_a_i,
    .uniform_b_i,
    .cmd_i  (cmd),
    .stat_o (stat),
    .sample_o,
    .clipped_o
  );

endmodule

FILE: rtl/core/pgsg_checker.sv
// pgsg_checker: port-level assertions for the polar Gaussian generator,
// bound to the top level. No package dependency.
module pgsg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] sample_o,
  input logic        clipped_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(sample_o) && $stable(clipped_o))
    else $error("stalled output word changed");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before the pair was done");

  a_clip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |-> (sample_o == 32'h7FFF_FFFF) ||
                                 (sample_o == 32'h8000_0000))
    else $error("clipped word not at a range bound");

endmodule

bind polar_gaussian_sample_generator_unit pgsg_checker u_pgsg_checker (.*);

FILE: dv/polar_gaussian_sample_generator_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for polar_gaussian_sample_generator_unit: drives uniform
// pairs and config writes, predicts each Gaussian word in fixed point or takes it from a table, and compares.
// Depends on pgsg_pkg and the RTL of the unit.
module polar_gaussian_sample_generator_unit_tb;
  import pgsg_pkg::*;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               clipped;
  } gauss_word_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_FIXED} row_kind_e;

  typedef struct packed {
    logic [31:0]        ua;
    logic [31:0]        ub;
    row_kind_e          kind;
    logic signed [31:0] sample;
    logic               clipped;
  } pair_row_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int PHASE_ITEMS    = 150;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CFG_MEAN;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] uniform_a_i = '0;
  logic [31:0] uniform_b_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [31:0] sample_o;
  logic        clipped_o;

  logic signed [31:0] mean_q = 32'sd0;
  logic [31:0]        sigma_q = SIGMA_RESET;
  logic               use_second_q = 1'b0;

  gauss_word_t expected_samples[$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  stall_left = 0;
  bit  quiet = 1'b0;

  polar_gaussian_sample_generator_unit u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gaussian word for one pair; returns 0 when the pair is rejected
  function automatic bit predict_sample(input logic [31:0] ua, input logic [31:0] ub,
                                        output gauss_word_t res);
    bit [63:0] half, a1, a2, w, av, m, z, f, nl2, lq, vsq, wn, vn, ratio, x2;
    bit [63:0] x, r, b, ax, mag;
    bit neg;
    int k, s;
    longint sum;
    half = 64'd1 << 31;
    a1 = (ua >= half) ? ua - half : half - ua;
    a2 = (ub >= half) ? ub - half : half - ub;
    w = a1 * a1 + a2 * a2;
    res = '0;
    if (w == 0 || w > (64'd1 << 62)) return 1'b0;
    av = use_second_q ? a2 : a1;
    neg = use_second_q ? (ub < half) : (ua < half);
    use_second_q = ~use_second_q;
    k = 0;
    while (k < 63 && (w >> (k + 1)) != 0) k++;
    m = (k >= 31) ? (w >> (k - 31)) : (w << (31 - k));
    f = 0;
    for (int i = 0; i < 32; i++) begin
      z = m * m;
      if (z[63]) begin
        f = (f << 1) | 64'd1;
        m = z >> 32;
      end else begin
        f = f << 1;
        m = z >> 31;
      end
    end
    nl2 = (64'(62 - k) << 32) - f;
    lq = (nl2 * 64'(TWO_LN2_Q24) + (64'd1 << 31)) >> 32;
    vsq = av * av;
    s = (k > 31) ? k - 31 : 0;
    wn = w >> s;
    vn = vsq >> s;
    ratio = (vn << 32) / wn;
    x2 = (ratio * lq) >> 24;
    x = x2 << 16;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    ax = r;
    mag = (64'(sigma_q) * ax + (64'd1 << 23)) >> 24;
    sum = longint'(mean_q) + (neg ? -longint'(mag) : longint'(mag));
    if (sum > 64'sd2147483647) begin
      sum = 64'sd2147483647;
      res.clipped = 1'b1;
    end else if (sum < -64'sd2147483648) begin
      sum = -64'sd2147483648;
      res.clipped = 1'b1;
    end
    res.sample = sum[31:0];
    return 1'b1;
  endfunction

  // result checking, receiver stalls and watchdog
  always @(posedge clk_i) begin
    gauss_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_samples.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: sample %0d clipped %0b", sample_o, clipped_o);
      end else begin
        exp_w = expected_samples.pop_front();
        if (sample_o !== exp_w.sample || clipped_o !== exp_w.clipped) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: sample exp %0d got %0d, clipped exp %0b got %0b",
                     exp_w.sample, sample_o, exp_w.clipped, clipped_o);
        end
      end
    end
    if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 6);
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
    if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("polar_gaussian_sample_generator_unit verification failed");
      $finish;
    end
  end

  task automatic send_pair(input logic [31:0] ua, input logic [31:0] ub,
                           input row_kind_e kind, input gauss_word_t fixed_w);
    gauss_word_t pred;
    in_valid_i <= 1'b1;
    uniform_a_i <= ua;
    uniform_b_i <= ub;
    do @(posedge clk_i); while (in_stall_o);
    if (predict_sample(ua, ub, pred) && kind == ROW_PREDICT) expected_samples.push_back(pred);
    if (kind == ROW_FIXED) expected_samples.push_back(fixed_w);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_samples.size() != 0 || in_stall_o) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] mean_v, input logic [31:0] sigma_v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_MEAN;
    cfg_data_i <= mean_v;
    @(posedge clk_i);
    cfg_idx_i <= CFG_SIGMA;
    cfg_data_i <= sigma_v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mean_q = mean_v;
    sigma_q = sigma_v;
  endtask

  function automatic logic [31:0] near_half();
    logic [31:0] d;
    d = $urandom_range(0, 65535);
    return $urandom_range(0, 1) ? 32'h8000_0000 + d : 32'h8000_0000 - d;
  endfunction

  function automatic logic [31:0] near_edge();
    logic [31:0] d;
    d = $urandom_range(0, 32'h3_FFFF);
    return $urandom_range(0, 1) ? 32'hDA82_0000 + d : 32'h257E_0000 - d;
  endfunction

  function automatic logic [31:0] extreme_value();
    case ($urandom_range(0, 4))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return 32'h8000_0001;
    endcase
  endfunction

  pair_row_t directed_rows[] = '{
    '{32'h0000_0000, 32'h0000_0000, ROW_NONE,    32'sd0, 1'b0},
    '{32'h8000_0000, 32'h8000_0000, ROW_NONE,    32'sd0, 1'b0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, ROW_NONE,    32'sd0, 1'b0},
    '{32'h0000_0000, 32'h8000_0000, ROW_FIXED,   32'sd0, 1'b0},
    '{32'h8000_0000, 32'h0000_0000, ROW_FIXED,   32'sd0, 1'b0},
    '{32'hFFFF_FFFF, 32'h8000_0000, ROW_PREDICT, 32'sd0, 1'b0},
    '{32'h8000_0000, 32'hFFFF_FFFF, ROW_PREDICT, 32'sd0, 1'b0},
    '{32'h0000_0001, 32'h8000_0000, ROW_PREDICT, 32'sd0, 1'b0},
    '{32'h8000_0001, 32'h8000_0000, ROW_PREDICT, 32'sd0, 1'b0},
    '{32'h8000_0000, 32'h7FFF_FFFF, ROW_PREDICT, 32'sd0, 1'b0},
    '{32'h7FFF_FFFF, 32'h8000_0001, ROW_PREDICT, 32'sd0, 1'b0},
    '{32'hC000_0000, 32'hC000_0000, ROW_PREDICT, 32'sd0, 1'b0},
    '{32'h4000_0000, 32'h4000_0000, ROW_PREDICT, 32'sd0, 1'b0},
    '{32'hAAAA_AAAA, 32'h5555_5555, ROW_PREDICT, 32'sd0, 1'b0},
    '{32'h5A5A_5A5A, 32'hA5A5_A5A5, ROW_PREDICT, 32'sd0, 1'b0},
    '{32'hDA82_799A, 32'hDA82_799A, ROW_PREDICT, 32'sd0, 1'b0},
    '{32'h257D_8666, 32'h257D_8666, ROW_PREDICT, 32'sd0, 1'b0},
    '{32'h8001_0000, 32'h7FFF_0000, ROW_PREDICT, 32'sd0, 1'b0},
    '{32'h1234_5678, 32'h9ABC_DEF0, ROW_PREDICT, 32'sd0, 1'b0},
    '{32'h0000_0000, 32'h7FFF_FFFF, ROW_PREDICT, 32'sd0, 1'b0}
  };

  logic [31:0] phase_mean[]  = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                 32'hFFFE_8000, 32'h1234_5678, 32'h0000_0000};
  logic [31:0] phase_sigma[] = '{32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'h0000_0000, 32'h0002_8000, 32'h0001_0000};

  initial begin
    gauss_word_t fixed_w;
    logic [31:0] ua, ub;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      fixed_w.sample = directed_rows[i].sample;
      fixed_w.clipped = directed_rows[i].clipped;
      send_pair(directed_rows[i].ua, directed_rows[i].ub, directed_rows[i].kind, fixed_w);
    end
    drain();
    foreach (phase_mean[p]) begin
      if (p == 4) set_config($urandom, $urandom_range(0, 32'h000F_FFFF));
      else set_config(phase_mean[p], phase_sigma[p]);
      quiet = (p == phase_mean.size() - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 9))
          6: begin ua = near_half(); ub = $urandom; end
          7: begin ua = near_edge(); ub = near_edge(); end
          8: begin ua = $urandom; ub = 32'h8000_0000; end
          9: begin ua = extreme_value(); ub = $urandom_range(0, 1) ? extreme_value() : $urandom; end
          default: begin ua = $urandom; ub = $urandom; end
        endcase
        if ($urandom_range(0, 1)) {ua, ub} = {ub, ua};
        send_pair(ua, ub, ROW_PREDICT, '0);
      end
      drain();
    end
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("polar_gaussian_sample_generator_unit verification clean");
    end else begin
      $display("polar_gaussian_sample_generator_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/pgsg_pkg.sv
rtl/core/pgsg_dp.sv
rtl/core/pgsg_ctrl.sv
rtl/core/polar_gaussian_sample_generator_unit.sv
rtl/core/pgsg_checker.sv
dv/polar_gaussian_sample_generator_unit_tb.sv
